// ----- rtl/uart_packet_framer_crc16_core_macros.svh -----
// Assertion macros shared by the framer modules.
`ifndef UART_PACKET_FRAMER_CRC16_CORE_MACROS_SVH
`define UART_PACKET_FRAMER_CRC16_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define UPFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define UPFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

// ----- rtl/upfc_pkg.sv -----
// Shared constants, request descriptor type and CRC-16 byte update for the framer.
package upfc_pkg;

    localparam logic [15:0] CrcPoly   = 16'h1021;
    localparam logic [7:0]  StartByte = 8'h02;
    localparam logic [7:0]  StopByte  = 8'h03;

    typedef struct packed {
        logic        hdr;
        logic [7:0]  len;
        logic [7:0]  data;
        logic        tail;
        logic [15:0] crc;
    } t_run;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/uart_packet_framer_crc16_core.sv -----
// Top level of the short-packet framer with CRC-16 trailer.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------
//  input    | i_valid  | o_stall  | i_payload_byte, i_payload_length
//  output   | o_valid  | i_stall  | o_out_byte, o_frame_end, o_run_last
//
// Each request produces 1 to 6 output bytes, one per cycle from the output
// register: 1 for a middle byte, 3 to open a frame, 3 more to close one.
// A new request is taken in the cycle that the last byte of the previous run
// is taken, so middle bytes stream at one per cycle while i_stall is low.
// Reset clears the frame count and CRC; the next request opens a new frame.
// Output stalls hold the current byte and back-pressure the input.

`include "uart_packet_framer_crc16_core_macros.svh"

module uart_packet_framer_crc16_core
    import upfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_payload_byte,
    input  logic [7:0] i_payload_length,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_run_last
);

    typedef enum logic [2:0] {
        PH_START,
        PH_LEN,
        PH_DATA,
        PH_CRCH,
        PH_CRCL,
        PH_STOP
    } t_phase;

    t_run   run;
    t_run   r_run;
    t_phase r_phase;
    t_phase n_phase;
    logic   r_valid;
    logic   take;
    logic   last;
    logic   accept;

    upfc_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (accept),
        .i_payload_byte   (i_payload_byte),
        .i_payload_length (i_payload_length),
        .o_run            (run)
    );

    always_comb begin
        last    = r_run.tail ? (r_phase == PH_STOP) : (r_phase == PH_DATA);
        take    = r_valid && !i_stall;
        o_stall = r_valid && !(take && last);
        accept  = i_valid && !o_stall;

        unique case (r_phase)
            PH_START: n_phase = PH_LEN;
            PH_LEN:   n_phase = PH_DATA;
            PH_DATA:  n_phase = PH_CRCH;
            PH_CRCH:  n_phase = PH_CRCL;
            PH_CRCL:  n_phase = PH_STOP;
            default:  n_phase = PH_STOP;
        endcase

        unique case (r_phase)
            PH_START: o_out_byte = StartByte;
            PH_LEN:   o_out_byte = r_run.len;
            PH_DATA:  o_out_byte = r_run.data;
            PH_CRCH:  o_out_byte = r_run.crc[15:8];
            PH_CRCL:  o_out_byte = r_run.crc[7:0];
            default:  o_out_byte = StopByte;
        endcase

        o_valid     = r_valid;
        o_frame_end = (r_phase == PH_STOP);
        o_run_last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_DATA;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_run   <= run;
            r_phase <= run.hdr ? PH_START : PH_DATA;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_phase <= n_phase;
            end
        end
    end

    `UPFC_ASSERT_NOW(a_end_is_last, o_valid && o_frame_end, o_run_last)
    `UPFC_ASSERT_NOW(a_accept_frees_slot, accept && r_valid, take && last)
    `UPFC_ASSERT_NEXT(a_run_continues, take && !last, o_valid && (r_phase != PH_START))
    `UPFC_ASSERT_NEXT(a_hdr_starts, accept && run.hdr, o_valid && (o_out_byte == StartByte))

endmodule

// ----- rtl/upfc_frame.sv -----
// Frame tracker: running CRC and byte count, builds the output run of each request.
`include "uart_packet_framer_crc16_core_macros.svh"

module upfc_frame
    import upfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_payload_byte,
    input  logic [7:0] i_payload_length,
    output t_run       o_run
);

    logic [15:0] r_crc;
    logic [7:0]  r_remaining;
    logic [15:0] n_crc;
    logic [7:0]  n_remaining;
    logic        open_frame;
    logic [7:0]  len_eff;
    logic [7:0]  rem_base;
    logic [15:0] crc_new;

    always_comb begin
        open_frame  = (r_remaining != 8'd0);
        len_eff     = (i_payload_length == 8'd0) ? 8'd1 : i_payload_length;
        rem_base    = open_frame ? r_remaining : len_eff;
        crc_new     = crc16_byte(open_frame ? r_crc : 16'h0000, i_payload_byte);
        n_remaining = rem_base - 8'd1;
        n_crc       = (n_remaining == 8'd0) ? 16'h0000 : crc_new;

        o_run.hdr  = !open_frame;
        o_run.len  = len_eff;
        o_run.data = i_payload_byte;
        o_run.tail = (n_remaining == 8'd0);
        o_run.crc  = crc_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 16'h0000;
            r_remaining <= 8'd0;
        end else if (i_take) begin
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
        end
    end

    `UPFC_ASSERT_NOW(a_idle_crc_clear, r_remaining == 8'd0, r_crc == 16'h0000)
    `UPFC_ASSERT_NEXT(a_tail_closes, i_take && o_run.tail, r_remaining == 8'd0)
    `UPFC_ASSERT_NEXT(a_mid_keeps_open, i_take && !o_run.tail, r_remaining != 8'd0)

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the CRC-16 short-packet framer core.
module tb;
    import upfc_pkg::*;

    localparam int RandItems = 184;
    localparam int BigLength = 128;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       run_last;
    } t_wire_byte;

    typedef struct packed {
        logic [7:0]      data;
        logic [7:0]      length;
        logic [2:0]      count;
        logic [0:5][7:0] bytes;
        logic            closes;
    } t_opening_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_payload_byte;
    logic [7:0] i_payload_length;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_frame_end;
    logic       o_run_last;

    logic [15:0]  crc_acc;
    logic [7:0]   frame_left;
    t_wire_byte   wire_q[$];
    t_wire_byte   framed_q[$];
    logic         idling_on;
    logic         cur_typed;
    t_opening_row cur_row;
    int           mismatches;

    t_opening_row opening_rows [16] = '{
        '{8'h00, 8'h00, 3'd6, {8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03}, 1'b1},
        '{8'hFF, 8'h01, 3'd0, 48'h0, 1'b0},
        '{8'hA5, 8'h02, 3'd3, {8'h02, 8'h02, 8'hA5, 24'h0}, 1'b0},
        '{8'h5A, 8'hFF, 3'd0, 48'h0, 1'b0},
        '{8'h00, 8'h03, 3'd3, {8'h02, 8'h03, 8'h00, 24'h0}, 1'b0},
        '{8'hFF, 8'h00, 3'd1, {8'hFF, 40'h0}, 1'b0},
        '{8'h01, 8'h80, 3'd0, 48'h0, 1'b0},
        '{8'h00, 8'h01, 3'd6, {8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03}, 1'b1},
        '{8'h12, 8'h04, 3'd3, {8'h02, 8'h04, 8'h12, 24'h0}, 1'b0},
        '{8'h34, 8'h00, 3'd1, {8'h34, 40'h0}, 1'b0},
        '{8'h56, 8'hFF, 3'd1, {8'h56, 40'h0}, 1'b0},
        '{8'h78, 8'h01, 3'd0, 48'h0, 1'b0},
        '{8'h7F, 8'h01, 3'd0, 48'h0, 1'b0},
        '{8'h80, 8'h00, 3'd0, 48'h0, 1'b0},
        '{8'h55, 8'h01, 3'd0, 48'h0, 1'b0},
        '{8'hAA, 8'h01, 3'd0, 48'h0, 1'b0}
    };

    uart_packet_framer_crc16_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_payload_byte   (i_payload_byte),
        .i_payload_length (i_payload_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_frame_end      (o_frame_end),
        .o_run_last       (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = (c[15] ^ b[i]) ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void frame_request(input logic [7:0] b, input logic [7:0] l);
        logic [7:0] n;
        t_wire_byte tail;
        n = (l == 8'd0) ? 8'd1 : l;
        framed_q.delete();
        if (frame_left == 8'd0) begin
            framed_q.push_back('{StartByte, 1'b0, 1'b0});
            framed_q.push_back('{n, 1'b0, 1'b0});
            crc_acc = '0;
            frame_left = n;
        end
        framed_q.push_back('{b, 1'b0, 1'b0});
        crc_acc = crc_step(crc_acc, b);
        frame_left = frame_left - 8'd1;
        if (frame_left == 8'd0) begin
            framed_q.push_back('{crc_acc[15:8], 1'b0, 1'b0});
            framed_q.push_back('{crc_acc[7:0], 1'b0, 1'b0});
            framed_q.push_back('{StopByte, 1'b1, 1'b0});
            crc_acc = '0;
        end
        tail = framed_q.pop_back();
        tail.run_last = 1'b1;
        framed_q.push_back(tail);
    endfunction

    always @(posedge i_clk) begin
        t_wire_byte got;
        t_wire_byte want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                frame_request(i_payload_byte, i_payload_length);
                if (cur_typed) begin
                    for (int k = 0; k < cur_row.count; k++) begin
                        wire_q.push_back('{cur_row.bytes[k],
                                           cur_row.closes && k == cur_row.count - 1,
                                           k == cur_row.count - 1});
                    end
                end else begin
                    foreach (framed_q[k]) wire_q.push_back(framed_q[k]);
                end
            end
            if (o_valid && !i_stall) begin
                got = '{o_out_byte, o_frame_end, o_run_last};
                if (wire_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte: got %h frame_end %b run_last %b",
                                 got.data, got.frame_end, got.run_last);
                end else begin
                    want = wire_q.pop_front();
                    if (got.data !== want.data || got.frame_end !== want.frame_end ||
                        got.run_last !== want.run_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     want.data, want.frame_end, want.run_last,
                                     got.data, got.frame_end, got.run_last);
                    end
                end
            end
        end
    end

    // hold the output side off in random bursts
    initial begin
        int burst;
        int run;
        burst = 0;
        run = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!idling_on) begin
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (run > 0) begin
                i_stall <= 1'b0;
                run--;
            end else if ($urandom_range(0, 2) == 0) begin
                burst = $urandom_range(1, 19);
            end else begin
                run = $urandom_range(1, 40);
            end
        end
    end

    task automatic send_request(input logic [7:0] b, input logic [7:0] l,
                                input logic typed, input t_opening_row row);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_payload_byte   <= b;
        i_payload_length <= l;
        cur_typed = typed;
        cur_row   = row;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        @(negedge i_clk);
    endtask

    initial begin
        int rand_items;
        int frame_idx;
        int flen;
        int nbytes;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_payload_byte   = 8'h00;
        i_payload_length = 8'h00;
        idling_on        = 1'b1;
        crc_acc          = '0;
        frame_left       = '0;
        cur_typed        = 1'b0;
        cur_row          = '0;
        mismatches       = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_rows[r]) begin
            send_request(opening_rows[r].data, opening_rows[r].length,
                         opening_rows[r].count != 3'd0, opening_rows[r]);
        end

        rand_items = 0;
        frame_idx  = 0;
        while (rand_items < RandItems) begin
            flen   = (frame_idx == 2) ? BigLength : $urandom_range(0, 12);
            nbytes = (flen == 0) ? 1 : flen;
            for (int j = 0; j < nbytes; j++) begin
                if (rand_items >= RandItems - 40)
                    idling_on = 1'b0;
                send_request(8'($urandom_range(0, 255)),
                             (j == 0) ? 8'(flen) : 8'($urandom_range(0, 255)),
                             1'b0, '0);
                rand_items++;
            end
            frame_idx++;
        end

        i_valid <= 1'b0;
        while (wire_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
